>>> rtl/core/gnfa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gnfa_pkg
// Shared types and constants for the greedy nearest-free assignment block.
// ----------------------------------------------------------------------------
package gnfa_pkg;

    localparam int GNFA_MAX_RESOURCES = 64;
    localparam int IDX_W   = 6;
    localparam int DIST_W  = 32;
    localparam int TOTAL_W = 48;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 96;

    typedef struct packed {
        logic [IDX_W-1:0]  resource_index;
        logic [DIST_W-1:0] distance;
        logic              last_in_column;
        logic              new_problem;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]   requester_index;
        logic [IDX_W-1:0]   chosen_resource;
        logic [DIST_W-1:0]  chosen_distance;
        logic [TOTAL_W-1:0] total_cost;
        logic               none_free;
    } result_t;

    // status from the output buffer back to the core
    typedef struct packed {
        logic full;
    } obuf_status_t;

endpackage
`default_nettype wire

>>> rtl/core/gnfa_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gnfa_core
// Input register, column minimum tracking, taken mask and saturating total.
// ----------------------------------------------------------------------------
module gnfa_core
    import gnfa_pkg::*;
#(
    parameter int MAX_RESOURCES = GNFA_MAX_RESOURCES
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire in_item_t     in_item,
    input  wire obuf_status_t obuf_status,
    output logic              res_push,
    output result_t           res_item
);

    localparam int MI_W = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam logic [IDX_W:0] MAX_R = (IDX_W+1)'(MAX_RESOURCES);
    localparam logic [TOTAL_W-1:0] TOTAL_SAT = '1;

    logic                     s1_valid_reg;
    in_item_t                 s1_item_reg;

    logic [MAX_RESOURCES-1:0] mask_reg, mask_next;
    logic [DIST_W-1:0]        best_dist_reg, best_dist_next;
    logic [IDX_W-1:0]         best_idx_reg, best_idx_next;
    logic                     found_reg, found_next;
    logic [IDX_W-1:0]         count_reg, count_next;
    logic [TOTAL_W-1:0]       total_reg, total_next;

    logic                     proc;
    logic [MAX_RESOURCES-1:0] eff_mask;
    logic [DIST_W-1:0]        eff_dist;
    logic [IDX_W-1:0]         eff_idx;
    logic                     eff_found;
    logic [IDX_W-1:0]         eff_count;
    logic [TOTAL_W-1:0]       eff_total;
    logic                     in_range, cand, upd;
    logic [DIST_W-1:0]        col_dist;
    logic [IDX_W-1:0]         col_idx;
    logic                     col_found;
    logic [TOTAL_W:0]         sum;
    logic [TOTAL_W-1:0]       new_total;

    // a column end needs a free output slot; other items always move on
    assign proc     = s1_valid_reg && (!s1_item_reg.last_in_column || !obuf_status.full);
    assign in_ready = !s1_valid_reg || proc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_ready) begin
            s1_valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            s1_item_reg <= in_item;
        end
    end

    always_comb begin
        if (s1_item_reg.new_problem) begin
            eff_mask  = '0;
            eff_dist  = '0;
            eff_idx   = '0;
            eff_found = 1'b0;
            eff_count = '0;
            eff_total = '0;
        end else begin
            eff_mask  = mask_reg;
            eff_dist  = best_dist_reg;
            eff_idx   = best_idx_reg;
            eff_found = found_reg;
            eff_count = count_reg;
            eff_total = total_reg;
        end

        in_range = {1'b0, s1_item_reg.resource_index} < MAX_R;
        cand     = in_range && !eff_mask[s1_item_reg.resource_index[MI_W-1:0]];
        upd      = cand && (!eff_found || s1_item_reg.distance < eff_dist ||
                   (s1_item_reg.distance == eff_dist &&
                    s1_item_reg.resource_index < eff_idx));

        col_found = eff_found || upd;
        col_dist  = upd ? s1_item_reg.distance : eff_dist;
        col_idx   = upd ? s1_item_reg.resource_index : eff_idx;

        sum       = {1'b0, eff_total} + {{(TOTAL_W+1-DIST_W){1'b0}}, col_dist};
        new_total = sum[TOTAL_W] ? TOTAL_SAT : sum[TOTAL_W-1:0];

        mask_next      = eff_mask;
        best_dist_next = col_dist;
        best_idx_next  = col_idx;
        found_next     = col_found;
        count_next     = eff_count;
        total_next     = eff_total;

        res_push = proc && s1_item_reg.last_in_column;
        res_item.requester_index = eff_count;
        res_item.chosen_resource = col_found ? col_idx : '0;
        res_item.chosen_distance = col_found ? col_dist : '0;
        res_item.total_cost      = col_found ? new_total : eff_total;
        res_item.none_free       = !col_found;

        if (s1_item_reg.last_in_column) begin
            if (col_found) begin
                for (int i = 0; i < MAX_RESOURCES; i++) begin
                    if (col_idx[MI_W-1:0] == MI_W'(i)) begin
                        mask_next[i] = 1'b1;
                    end
                end
                total_next = new_total;
            end
            count_next     = eff_count + 1'b1;
            found_next     = 1'b0;
            best_dist_next = '0;
            best_idx_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg      <= '0;
            best_dist_reg <= '0;
            best_idx_reg  <= '0;
            found_reg     <= 1'b0;
            count_reg     <= '0;
            total_reg     <= '0;
        end else if (proc) begin
            mask_reg      <= mask_next;
            best_dist_reg <= best_dist_next;
            best_idx_reg  <= best_idx_next;
            found_reg     <= found_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
        end
    end

`ifndef SYNTH
    // an assignment takes exactly one more resource
    a_mask_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && s1_item_reg.last_in_column && col_found && !s1_item_reg.new_problem
        |=> $countones(mask_reg) == $past($countones(mask_reg)) + 1)
        else $error("taken mask did not grow by one resource");
    a_col_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && s1_item_reg.last_in_column |=> !found_reg)
        else $error("column minimum not cleared at column end");
    a_total_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && !s1_item_reg.new_problem |=> total_reg >= $past(total_reg))
        else $error("total cost decreased without a new problem");
`endif

endmodule
`default_nettype wire

>>> rtl/core/gnfa_obuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gnfa_obuf
// Two-entry result buffer; decouples the core from output backpressure.
// ----------------------------------------------------------------------------
module gnfa_obuf
    import gnfa_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire result_t push_item,
    output obuf_status_t status,
    output logic        out_valid,
    input  wire logic   out_ready,
    output result_t     out_item
);

    result_t    entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign pop          = out_valid && out_ready;
    assign out_valid    = count_reg != 2'd0;
    assign out_item     = entry_reg[rd_ptr_reg];
    assign status.full  = count_reg == 2'd2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !status.full)
        else $error("result pushed into full buffer");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result buffer count out of range");
`endif

endmodule
`default_nettype wire

>>> rtl/core/greedy_nearest_free_assignment.sv
`default_nettype none
// A column-ending item's result passes the input register, then the result
// buffer register, before it shows on the output.
// Throughput: 1 item per cycle; the combinational compare/add stage sets it.
// Input stalls only when the two-entry result buffer is full.
// Reset (aresetn low, synchronous) empties the pipe and clears mask,
// column minimum, requester count and total.
// ----------------------------------------------------------------------------
// greedy_nearest_free_assignment
// Assigns each requester the nearest untaken resource from its distance column.
// ----------------------------------------------------------------------------
module greedy_nearest_free_assignment
    import gnfa_pkg::*;
#(
    parameter int MAX_RESOURCES = GNFA_MAX_RESOURCES
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // [5:0] resource_index, [37:6] distance, [39:38] zero
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    input  wire logic                 s_axis_tlast,   // last_in_column
    input  wire logic                 s_axis_tuser,   // new_problem
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [5:0] requester_index, [11:6] chosen_resource, [43:12] chosen_distance,
    // [91:44] total_cost, [95:92] zero
    output logic [M_TDATA_W-1:0]      m_axis_tdata,
    output logic                      m_axis_tuser    // none_free
);

    in_item_t     in_item;
    result_t      res_item, out_item;
    logic         res_push;
    obuf_status_t obuf_status;

    assign in_item.resource_index = s_axis_tdata[IDX_W-1:0];
    assign in_item.distance       = s_axis_tdata[IDX_W+DIST_W-1:IDX_W];
    assign in_item.last_in_column = s_axis_tlast;
    assign in_item.new_problem    = s_axis_tuser;

    gnfa_core #(
        .MAX_RESOURCES(MAX_RESOURCES)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_item     (in_item),
        .obuf_status (obuf_status),
        .res_push    (res_push),
        .res_item    (res_item)
    );

    gnfa_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_item (res_item),
        .status    (obuf_status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (out_item)
    );

    assign m_axis_tdata = {4'b0000, out_item.total_cost, out_item.chosen_distance,
                           out_item.chosen_resource, out_item.requester_index};
    assign m_axis_tuser = out_item.none_free;

endmodule
`default_nettype wire
